// ===== rtl/sbu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbu_pkg: shared types and codes of the software breakpoint unit
// Command modes, result dispositions, sequencer states and the control and
// status words passed between the sequencer and the breakpoint table.
// ----------------------------------------------------------------------------
package sbu_pkg;

  // command modes
  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_REMOVE   = 3'd1;
  localparam logic [2:0] MODE_BP_TRAP  = 3'd2;
  localparam logic [2:0] MODE_DBG_TRAP = 3'd3;
  localparam logic [2:0] MODE_RESUME   = 3'd4;

  // result dispositions
  localparam logic [1:0] DISP_PASS    = 2'd0;
  localparam logic [1:0] DISP_SESSION = 2'd1;
  localparam logic [1:0] DISP_SILENT  = 2'd2;
  localparam logic [1:0] DISP_DONE    = 2'd3;

  // trap opcode planted over the original byte
  localparam logic [7:0] TRAP_OPCODE = 8'hCC;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } sbu_state_t;

  // sequencer to table
  typedef struct packed {
    logic scan;      // start a scan of the table against the key
    logic set_used;  // claim the write slot, storing address and byte
    logic clr_used;  // release the write slot
  } sbu_tbl_ctrl_t;

  // table to sequencer
  typedef struct packed {
    logic done;      // last entry compared this cycle
    logic hit;       // a used entry matched the key
    logic free;      // a free slot was seen
  } sbu_tbl_stat_t;

endpackage

// ===== rtl/sbu_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbu_table: breakpoint table with a sequential scan
// Used bits in flip-flops, addresses and saved bytes in a memory with a
// registered read port. One 64-bit comparator walks the entries, one a
// cycle, recording the first match and the first free slot.
// ----------------------------------------------------------------------------
module sbu_table
  import sbu_pkg::*;
#(
  parameter int NUM_BREAKPOINTS = 32,
  parameter int IW = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sbu_tbl_ctrl_t ctrl_i,
  input  logic [63:0]   key_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [63:0]   wr_addr_i,
  input  logic [7:0]    wr_byte_i,
  output sbu_tbl_stat_t stat_o,
  output logic [IW-1:0] hit_idx_o,
  output logic [7:0]    hit_byte_o,
  output logic [IW-1:0] free_idx_o
);

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BREAKPOINTS - 1);

  logic [NUM_BREAKPOINTS-1:0] used_r;
  logic [63:0] mem_addr [NUM_BREAKPOINTS];
  logic [7:0]  mem_byte [NUM_BREAKPOINTS];

  logic          issue_r;
  logic [IW-1:0] idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic [63:0]   rd_addr_r;
  logic [7:0]    rd_byte_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [7:0]    hit_byte_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;

  logic cmp_match;
  logic cmp_free;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl_i.set_used) begin
      mem_addr[wr_idx_i] <= wr_addr_i;
      mem_byte[wr_idx_i] <= wr_byte_i;
    end
    rd_addr_r <= mem_addr[idx_r];
    rd_byte_r <= mem_byte[idx_r];
  end

  // used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctrl_i.set_used) begin
      used_r[wr_idx_i] <= 1'b1;
    end else if (ctrl_i.clr_used) begin
      used_r[wr_idx_i] <= 1'b0;
    end
  end

  // read issue counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      cmp_idx_r <= '0;
    end else begin
      cmp_vld_r <= issue_r;
      cmp_idx_r <= idx_r;
      if (ctrl_i.scan) begin
        issue_r <= 1'b1;
        idx_r   <= '0;
      end else if (issue_r) begin
        if (idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // shared comparator on the entry just read
  assign cmp_match = cmp_vld_r && used_r[cmp_idx_r] && (rd_addr_r == key_i);
  assign cmp_free  = cmp_vld_r && !used_r[cmp_idx_r];

  // first match and first free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctrl_i.scan) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (cmp_match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (cmp_free && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_match && !hit_r) begin
      hit_idx_r  <= cmp_idx_r;
      hit_byte_r <= rd_byte_r;
    end
    if (cmp_free && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  assign stat_o.done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign stat_o.hit  = hit_r;
  assign stat_o.free = free_r;
  assign hit_idx_o   = hit_idx_r;
  assign hit_byte_o  = hit_byte_r;
  assign free_idx_o  = free_idx_r;

endmodule

// ===== rtl/software_breakpoint_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_breakpoint_unit: software breakpoint table with step-over
// Handles add/remove commands, breakpoint and debug traps and resume,
// requesting memory byte writes, pc rewinds and trap flag updates.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  --------  ----------------------------  ------------------------------
//  command   start, busy, in_*             word taken when start & !busy
//  result    out_strobe, out_*             one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_*   word taken when valid & ready
//
// A word is taken only while the unit is idle, so words never overlap: the
// single table comparator visits one entry a cycle during the scan, then the
// execute state runs and the result strobes while busy is already low.
// Reset empties the table at once and clears the step-over state.
// The result side never stalls; the user writes config while the unit is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module software_breakpoint_unit
  import sbu_pkg::*;
#(
  parameter int NUM_BREAKPOINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_address,
  input  logic [7:0]  in_mem_byte,
  input  logic        in_step_req,
  // result
  output logic        out_strobe,
  output logic        out_status,
  output logic [1:0]  out_disposition,
  output logic        out_mem_write,
  output logic [63:0] out_write_address,
  output logic [7:0]  out_write_byte,
  output logic        out_pc_update,
  output logic [63:0] out_new_pc,
  output logic        out_trap_flag_write,
  output logic        out_trap_flag,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_enabled
);

  localparam int IW = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;

  sbu_state_t state_r, state_nxt;

  logic        enabled_r;
  logic [2:0]  mode_r;
  logic [63:0] addr_r;
  logic [7:0]  byte_r;
  logic        ss_r;
  logic [63:0] key_r;

  logic        pend_r, pend_nxt;
  logic [63:0] pend_addr_r, pend_addr_nxt;
  logic        cont_r, cont_nxt;

  // result word as computed in the execute cycle
  logic        res_status;
  logic [1:0]  res_disp;
  logic        res_mw;
  logic [63:0] res_waddr;
  logic [7:0]  res_wbyte;
  logic        res_pcu;
  logic [63:0] res_npc;
  logic        res_tfw;
  logic        res_tf;
  logic        res_set_used;
  logic        res_clr_used;

  logic        strobe_r;
  logic        status_r;
  logic [1:0]  disp_r;
  logic        mw_r;
  logic [63:0] waddr_r;
  logic [7:0]  wbyte_r;
  logic        pcu_r;
  logic [63:0] npc_r;
  logic        tfw_r;
  logic        tf_r;

  sbu_tbl_ctrl_t tbl_ctrl;
  sbu_tbl_stat_t tbl_stat;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] hit_idx;
  logic [7:0]    hit_byte;
  logic [IW-1:0] free_idx;

  logic accept;
  logic exec;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enabled_r <= cfg_enabled;
    end
  end

  // command word capture; a breakpoint trap looks up pc - 1
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      addr_r <= in_address;
      byte_r <= in_mem_byte;
      ss_r   <= in_step_req;
      case (in_mode)
        MODE_BP_TRAP:  key_r <= in_address - 64'd1;
        MODE_DBG_TRAP: key_r <= pend_addr_r;
        default:       key_r <= in_address;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (tbl_stat.done) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: outputs
  always_comb begin
    busy          = 1'b1;
    exec          = 1'b0;
    tbl_ctrl.scan = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        tbl_ctrl.scan = start;
      end
      ST_SCAN: ;
      ST_EXEC: exec = 1'b1;
      default: ;
    endcase
    tbl_ctrl.set_used = exec && res_set_used;
    tbl_ctrl.clr_used = exec && res_clr_used;
  end

  assign wr_idx = (mode_r == MODE_ADD) ? free_idx : hit_idx;

  // command execution on the scan outcome
  always_comb begin
    res_status    = 1'b0;
    res_disp      = DISP_DONE;
    res_mw        = 1'b0;
    res_waddr     = '0;
    res_wbyte     = '0;
    res_pcu       = 1'b0;
    res_npc       = '0;
    res_tfw       = 1'b0;
    res_tf        = 1'b0;
    res_set_used  = 1'b0;
    res_clr_used  = 1'b0;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cont_nxt      = cont_r;
    case (mode_r)
      MODE_ADD: begin
        if (!tbl_stat.hit) begin
          if (!tbl_stat.free) begin
            res_status = 1'b1;
          end else begin
            res_set_used = 1'b1;
            res_mw       = 1'b1;
            res_waddr    = addr_r;
            res_wbyte    = TRAP_OPCODE;
          end
        end
      end
      MODE_REMOVE: begin
        if (!tbl_stat.hit) begin
          res_status = 1'b1;
        end else begin
          res_clr_used = 1'b1;
          res_mw       = 1'b1;
          res_waddr    = addr_r;
          res_wbyte    = hit_byte;
        end
      end
      MODE_BP_TRAP: begin
        if (!enabled_r) begin
          res_disp = DISP_PASS;
        end else begin
          res_disp = DISP_SESSION;
          if (tbl_stat.hit) begin
            res_mw        = 1'b1;
            res_waddr     = key_r;
            res_wbyte     = hit_byte;
            res_pcu       = 1'b1;
            res_npc       = key_r;
            pend_nxt      = 1'b1;
            pend_addr_nxt = key_r;
          end
        end
      end
      MODE_DBG_TRAP: begin
        if (!enabled_r) begin
          res_disp = DISP_PASS;
        end else if (cont_r) begin
          res_disp = DISP_SILENT;
          res_tfw  = 1'b1;
          if (pend_r) begin
            // re-arm unless it was removed meanwhile
            if (tbl_stat.hit) begin
              res_mw    = 1'b1;
              res_waddr = pend_addr_r;
              res_wbyte = TRAP_OPCODE;
            end
            pend_nxt      = 1'b0;
            pend_addr_nxt = '0;
          end
          cont_nxt = 1'b0;
        end else begin
          res_disp = DISP_SESSION;
        end
      end
      MODE_RESUME: begin
        res_tfw = 1'b1;
        if (pend_r) begin
          res_tf   = 1'b1;
          cont_nxt = !ss_r;
        end else begin
          res_tf = ss_r;
        end
      end
      default: res_status = 1'b1;
    endcase
  end

  // step-over state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
      cont_r      <= 1'b0;
    end else if (exec) begin
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
      cont_r      <= cont_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r <= res_status;
      disp_r   <= res_disp;
      mw_r     <= res_mw;
      waddr_r  <= res_waddr;
      wbyte_r  <= res_wbyte;
      pcu_r    <= res_pcu;
      npc_r    <= res_npc;
      tfw_r    <= res_tfw;
      tf_r     <= res_tf;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_disposition     = disp_r;
  assign out_mem_write       = mw_r;
  assign out_write_address   = waddr_r;
  assign out_write_byte      = wbyte_r;
  assign out_pc_update       = pcu_r;
  assign out_new_pc          = npc_r;
  assign out_trap_flag_write = tfw_r;
  assign out_trap_flag       = tf_r;

  // breakpoint table
  sbu_table #(
    .NUM_BREAKPOINTS (NUM_BREAKPOINTS),
    .IW              (IW)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (tbl_ctrl),
    .key_i      (key_r),
    .wr_idx_i   (wr_idx),
    .wr_addr_i  (addr_r),
    .wr_byte_i  (byte_r),
    .stat_o     (tbl_stat),
    .hit_idx_o  (hit_idx),
    .hit_byte_o (hit_byte),
    .free_idx_o (free_idx)
  );

endmodule

// ===== rtl/sbu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbu_checker: port-level checks of the software breakpoint unit
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module sbu_checker
  import sbu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_status,
  input logic [1:0]  out_disposition,
  input logic        out_mem_write,
  input logic [63:0] out_write_address,
  input logic        out_pc_update,
  input logic [63:0] out_new_pc,
  input logic        out_trap_flag_write
);

  // an accepted word keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a word");

  // results never come in consecutive cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // the result cycle already frees the command side
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy during result strobe");

  // a pass-through trap asks for nothing
  a_pass_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_disposition == DISP_PASS) |->
      (!out_mem_write && !out_pc_update && !out_trap_flag_write && !out_status))
    else $error("pass-through trap requested an action");

  // a pc rewind always restores the byte at the new pc
  a_rewind_restore: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pc_update) |->
      (out_mem_write && out_write_address == out_new_pc))
    else $error("pc rewind without matching byte restore");

endmodule

bind software_breakpoint_unit sbu_checker u_sbu_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_status          (out_status),
  .out_disposition     (out_disposition),
  .out_mem_write       (out_mem_write),
  .out_write_address   (out_write_address),
  .out_pc_update       (out_pc_update),
  .out_new_pc          (out_new_pc),
  .out_trap_flag_write (out_trap_flag_write)
);

// ===== tb/software_breakpoint_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_breakpoint_unit_test: self-checking bench for the breakpoint unit
// A short table of directed requests covers the corners: empty and duplicate
// adds, removes, reserved modes, traps while disabled, address wrap and the
// step-over sequence. Six random phases follow under three idling profiles and
// both enable settings. Every result word is checked against a fixed directed
// answer or a bench model of the breakpoint table and the step-over state.
// ----------------------------------------------------------------------------
module software_breakpoint_unit_test;
  import sbu_pkg::*;

  localparam int          NUM_BP      = 32;
  localparam int          CLK_PERIOD  = 8;
  localparam int          POOL_SIZE   = 40;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_WORDS = 150;
  localparam int          NUM_PHASES  = 6;
  localparam int          DIR_ROWS    = 23;
  localparam int          MAX_GAP     = 45;
  localparam logic [63:0] ADDR_TOP    = {64{1'b1}};
  // modes the unit treats as reserved
  localparam logic [2:0]  MODE_RSVD_LO = 3'd5;
  localparam logic [2:0]  MODE_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] address;
    logic [7:0]  mem_byte;
    logic        step_req;
  } bp_cmd_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  disposition;
    logic        mem_write;
    logic [63:0] write_address;
    logic [7:0]  write_byte;
    logic        pc_update;
    logic [63:0] new_pc;
    logic        trap_flag_write;
    logic        trap_flag;
  } bp_result_t;

  // one directed row: enable setting, request, and an optional fixed answer
  typedef struct packed {
    logic       en;
    bp_cmd_t    cmd;
    logic       typed;
    bp_result_t res;
  } bp_row_t;

  localparam bp_result_t RES_PASS =
    '{1'b0, DISP_PASS, 1'b0, 64'd0, 8'h00, 1'b0, 64'd0, 1'b0, 1'b0};
  localparam bp_result_t RES_FAIL =
    '{1'b1, DISP_DONE, 1'b0, 64'd0, 8'h00, 1'b0, 64'd0, 1'b0, 1'b0};
  localparam bp_result_t RES_OK =
    '{1'b0, DISP_DONE, 1'b0, 64'd0, 8'h00, 1'b0, 64'd0, 1'b0, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [63:0] in_address = '0;
  logic [7:0]  in_mem_byte = '0;
  logic        in_step_req = 1'b0;
  logic        out_strobe;
  logic        out_status;
  logic [1:0]  out_disposition;
  logic        out_mem_write;
  logic [63:0] out_write_address;
  logic [7:0]  out_write_byte;
  logic        out_pc_update;
  logic [63:0] out_new_pc;
  logic        out_trap_flag_write;
  logic        out_trap_flag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_enabled = 1'b0;

  // bench copy of the table and step-over state
  logic        slot_used [NUM_BP];
  logic [63:0] slot_addr [NUM_BP];
  logic [7:0]  slot_byte [NUM_BP];
  logic        pend_valid;
  logic [63:0] pend_addr;
  logic        step_continue;
  logic        dbg_enabled;

  bp_result_t  outcome_q [$];
  bp_row_t     dir_rows [DIR_ROWS];
  logic [63:0] addr_pool [POOL_SIZE];
  int          phase_add_w [NUM_PHASES] = '{30, 60, 30, 35, 60, 30};
  logic        phase_en [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int          idle_pct = 21;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  software_breakpoint_unit #(
    .NUM_BREAKPOINTS(NUM_BP)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_mem_byte         (in_mem_byte),
    .in_step_req         (in_step_req),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_disposition     (out_disposition),
    .out_mem_write       (out_mem_write),
    .out_write_address   (out_write_address),
    .out_write_byte      (out_write_byte),
    .out_pc_update       (out_pc_update),
    .out_new_pc          (out_new_pc),
    .out_trap_flag_write (out_trap_flag_write),
    .out_trap_flag       (out_trap_flag),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_enabled         (cfg_enabled)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // used slot holding addr, or -1
  function automatic int find_slot(logic [63:0] addr);
    for (int i = 0; i < NUM_BP; i++) begin
      if (slot_used[i] && slot_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // a random used slot, or -1 with the table empty
  function automatic int pick_used_slot();
    int n;
    int nth;
    n = 0;
    for (int i = 0; i < NUM_BP; i++) if (slot_used[i]) n++;
    if (n == 0) return -1;
    nth = $urandom_range(n - 1);
    for (int i = 0; i < NUM_BP; i++) begin
      if (slot_used[i]) begin
        if (nth == 0) return i;
        nth--;
      end
    end
    return -1;
  endfunction

  // outcome of one request; updates the bench state
  function automatic bp_result_t breakpoint_outcome(bp_cmd_t c);
    bp_result_t  r;
    int          k;
    logic [63:0] hit;
    r = '0;
    r.disposition = DISP_DONE;
    hit = c.address - 64'd1;
    case (c.mode)
      MODE_ADD: begin
        if (find_slot(c.address) < 0) begin
          k = -1;
          for (int i = NUM_BP - 1; i >= 0; i--) if (!slot_used[i]) k = i;
          if (k < 0) begin
            r.status = 1'b1;
          end else begin
            slot_used[k] = 1'b1;
            slot_addr[k] = c.address;
            slot_byte[k] = c.mem_byte;
            r.mem_write = 1'b1;
            r.write_address = c.address;
            r.write_byte = TRAP_OPCODE;
          end
        end
      end
      MODE_REMOVE: begin
        k = find_slot(c.address);
        if (k < 0) begin
          r.status = 1'b1;
        end else begin
          r.mem_write = 1'b1;
          r.write_address = c.address;
          r.write_byte = slot_byte[k];
          slot_used[k] = 1'b0;
        end
      end
      MODE_BP_TRAP: begin
        if (!dbg_enabled) begin
          r.disposition = DISP_PASS;
        end else begin
          r.disposition = DISP_SESSION;
          k = find_slot(hit);
          if (k >= 0) begin
            r.mem_write = 1'b1;
            r.write_address = hit;
            r.write_byte = slot_byte[k];
            r.pc_update = 1'b1;
            r.new_pc = hit;
            pend_valid = 1'b1;
            pend_addr = hit;
          end
        end
      end
      MODE_DBG_TRAP: begin
        if (!dbg_enabled) begin
          r.disposition = DISP_PASS;
        end else if (step_continue) begin
          r.disposition = DISP_SILENT;
          r.trap_flag_write = 1'b1;
          if (pend_valid) begin
            // re-arm only if the breakpoint is still in the table
            if (find_slot(pend_addr) >= 0) begin
              r.mem_write = 1'b1;
              r.write_address = pend_addr;
              r.write_byte = TRAP_OPCODE;
            end
            pend_valid = 1'b0;
            pend_addr = '0;
          end
          step_continue = 1'b0;
        end else begin
          r.disposition = DISP_SESSION;
        end
      end
      MODE_RESUME: begin
        r.trap_flag_write = 1'b1;
        if (pend_valid) begin
          r.trap_flag = 1'b1;
          step_continue = !c.step_req;
        end else begin
          r.trap_flag = c.step_req;
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // present one word, wait for it to be taken, then maybe hold off
  task automatic send_request(bp_cmd_t c, logic typed, bp_result_t fixed_res);
    bp_result_t want;
    start       <= 1'b1;
    in_mode     <= c.mode;
    in_address  <= c.address;
    in_mem_byte <= c.mem_byte;
    in_step_req <= c.step_req;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = breakpoint_outcome(c);
    outcome_q.push_back(typed ? fixed_res : want);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has arrived
  task automatic drain_results();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    cfg_enabled <= value;
    cfg_valid   <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dbg_enabled = value;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    bp_result_t want;
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_strobe) begin
      if (outcome_q.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("disposition", want.disposition, out_disposition);
        check_field("mem_write", want.mem_write, out_mem_write);
        check_field("write_address", want.write_address, out_write_address);
        check_field("write_byte", want.write_byte, out_write_byte);
        check_field("pc_update", want.pc_update, out_pc_update);
        check_field("new_pc", want.new_pc, out_new_pc);
        check_field("trap_flag_write", want.trap_flag_write, out_trap_flag_write);
        check_field("trap_flag", want.trap_flag, out_trap_flag);
      end
    end
  end

  // stimulus
  initial begin
    bp_cmd_t c;
    int      k;
    int      w;
    int      sent;
    logic    coin;

    for (int i = 0; i < NUM_BP; i++) begin
      slot_used[i] = 1'b0;
      slot_addr[i] = '0;
      slot_byte[i] = '0;
    end
    pend_valid    = 1'b0;
    pend_addr     = '0;
    step_continue = 1'b0;
    dbg_enabled   = 1'b0;

    // a few addresses at each end of the space, the rest scattered
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 4) addr_pool[i] = 64'(i);
      else if (i < 8) addr_pool[i] = ADDR_TOP - 64'(i - 4);
      else addr_pool[i] = {$urandom, $urandom};
    end

    dir_rows = '{
      // disabled: traps pass straight through
      '{1'b0, '{MODE_BP_TRAP, 64'd0, 8'h00, 1'b0}, 1'b1, RES_PASS},
      '{1'b0, '{MODE_DBG_TRAP, ADDR_TOP, 8'hFF, 1'b1}, 1'b1, RES_PASS},
      // remove on an empty table, reserved modes
      '{1'b0, '{MODE_REMOVE, 64'd0, 8'h00, 1'b0}, 1'b1, RES_FAIL},
      '{1'b0, '{MODE_RSVD_LO, ADDR_TOP, 8'hFF, 1'b1}, 1'b1, RES_FAIL},
      '{1'b0, '{MODE_RSVD_HI, 64'd0, 8'h00, 1'b0}, 1'b1, RES_FAIL},
      // commands act while disabled
      '{1'b0, '{MODE_ADD, 64'd0, 8'h00, 1'b0}, 1'b1,
          '{1'b0, DISP_DONE, 1'b1, 64'd0, TRAP_OPCODE, 1'b0, 64'd0, 1'b0, 1'b0}},
      '{1'b0, '{MODE_ADD, ADDR_TOP, 8'hFF, 1'b1}, 1'b1,
          '{1'b0, DISP_DONE, 1'b1, ADDR_TOP, TRAP_OPCODE, 1'b0, 64'd0, 1'b0, 1'b0}},
      // duplicate add succeeds without a write
      '{1'b0, '{MODE_ADD, 64'd0, 8'h5A, 1'b0}, 1'b1, RES_OK},
      // resume with nothing pending: flag follows the step request
      '{1'b0, '{MODE_RESUME, 64'd0, 8'h00, 1'b1}, 1'b1,
          '{1'b0, DISP_DONE, 1'b0, 64'd0, 8'h00, 1'b0, 64'd0, 1'b1, 1'b1}},
      '{1'b0, '{MODE_RESUME, ADDR_TOP, 8'hFF, 1'b0}, 1'b1,
          '{1'b0, DISP_DONE, 1'b0, 64'd0, 8'h00, 1'b0, 64'd0, 1'b1, 1'b0}},
      // enabled: hit, step over, silent re-arm
      '{1'b1, '{MODE_BP_TRAP, 64'd1, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_RESUME, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_DBG_TRAP, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      // pc of zero wraps onto the top address
      '{1'b1, '{MODE_BP_TRAP, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_RESUME, 64'd0, 8'h00, 1'b1}, 1'b0, '0},
      '{1'b1, '{MODE_DBG_TRAP, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_RESUME, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      // pending breakpoint removed before the step trap
      '{1'b1, '{MODE_REMOVE, ADDR_TOP, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_DBG_TRAP, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      // miss, then a step trap with nothing to continue
      '{1'b1, '{MODE_BP_TRAP, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_DBG_TRAP, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b1, '{MODE_REMOVE, 64'd0, 8'h00, 1'b0}, 1'b0, '0},
      // disabled again
      '{1'b0, '{MODE_BP_TRAP, 64'd1, 8'h00, 1'b0}, 1'b1, RES_PASS}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the enable is changed only with the unit idle
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].en !== dbg_enabled) begin
        drain_results();
        write_enable(dir_rows[i].en);
      end
      send_request(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_enable(phase_en[ph]);
      idle_pct = (ph < 2) ? 21 : (ph < 4) ? 69 : 0;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        c.mem_byte = 8'($urandom);
        c.step_req = 1'($urandom);
        if (dbg_enabled && $urandom_range(99) < 30) begin
          // step-over sequence: trap past a breakpoint, resume, step trap
          k = pick_used_slot();
          c.mode    = MODE_BP_TRAP;
          c.address = (k >= 0) ? slot_addr[k] + 64'd1
                               : addr_pool[$urandom_range(POOL_SIZE - 1)];
          send_request(c, 1'b0, '0);
          c.mode     = MODE_RESUME;
          c.step_req = ($urandom_range(3) == 0);
          send_request(c, 1'b0, '0);
          sent += 3;
          if ($urandom_range(3) == 0) begin
            c.mode    = MODE_REMOVE;
            c.address = pend_addr;
            send_request(c, 1'b0, '0);
            sent++;
          end
          c.mode = MODE_DBG_TRAP;
          send_request(c, 1'b0, '0);
        end else begin
          w = $urandom_range(phase_add_w[ph] + 54);
          if (w < phase_add_w[ph]) c.mode = MODE_ADD;
          else if (w < phase_add_w[ph] + 15) c.mode = MODE_REMOVE;
          else if (w < phase_add_w[ph] + 30) c.mode = MODE_BP_TRAP;
          else if (w < phase_add_w[ph] + 40) c.mode = MODE_DBG_TRAP;
          else if (w < phase_add_w[ph] + 50) c.mode = MODE_RESUME;
          else c.mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
          // aim traps and removes at live breakpoints half the time
          k    = pick_used_slot();
          coin = 1'($urandom);
          if (k >= 0 && coin && c.mode == MODE_BP_TRAP)
            c.address = slot_addr[k] + 64'd1;
          else if (k >= 0 && coin && c.mode == MODE_REMOVE)
            c.address = slot_addr[k];
          else if ($urandom_range(4) == 0)
            c.address = {$urandom, $urandom};
          else
            c.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
          send_request(c, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(99) < 2) drain_results();
      end
    end

    // let everything land, then watch a while for stray strobes
    drain_results();
    repeat (NUM_BP + 8) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== software_breakpoint_unit.f =====
rtl/sbu_pkg.sv
rtl/sbu_table.sv
rtl/software_breakpoint_unit.sv
rtl/sbu_checker.sv
tb/software_breakpoint_unit_test.sv
